[rtl/sync_length_crc16_deframer_defines.svh]
// Assertion macros used by the assertion checker file of the deframer.
`ifndef SYNC_LENGTH_CRC16_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CRC16_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam int MAX_FRAME_DEF = 1024;

  localparam logic [7:0] SYNC_ONE = 8'h24;
  localparam logic [7:0] SYNC_TWO = 8'h40;

  // Header byte positions within a frame
  localparam int IDX_CRC_LO = 2;
  localparam int IDX_CRC_HI = 3;
  localparam int IDX_ID_LO  = 4;
  localparam int IDX_ID_HI  = 5;
  localparam int IDX_LEN_LO = 6;
  localparam int IDX_LEN_HI = 7;
  localparam int IDX_CRC_START = IDX_ID_LO;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd8;

  localparam int BYTE_INDEX_W = 10;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 56;
  localparam int OUT_TUSER_W  = 4;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_RECV    = 3'd1,
    ST_GOOD    = 3'd2,
    ST_CRC_ERR = 3'd3,
    ST_LEN_ERR = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_SYNC = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0]              echo_byte;
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic                    in_frame;
    logic                    frame_end;
    status_e                 status;
    logic [15:0]             message_id;
    logic [15:0]             frame_length;
  } res_t;

  // One byte of CRC-16 CCITT, polynomial 0x1021, MSB first
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

`default_nettype wire

[rtl/sld_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// Single register slice with valid/ready; accepts while the held entry drains.
module sld_stage #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic [W-1:0] data_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output logic [W-1:0]      data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/sld_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sync hunt, header capture and running CRC; one byte per advance.
module sld_parser #(
  parameter int MAX_FRAME = sld_pkg::MAX_FRAME_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] data_i,
  output sld_pkg::res_t   res_o
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  sld_pkg::phase_e phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic [15:0] crc_q, crc_d;
  logic [15:0] exp_q, exp_d;
  logic [15:0] id_q, id_d;
  logic [15:0] len_q, len_d;
  logic        end_hit;

  assign cnt_inc = cnt_q + CNT_W'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    exp_d   = exp_q;
    id_d    = id_q;
    len_d   = len_q;
    end_hit = 1'b0;

    res_o.echo_byte    = data_i;
    res_o.byte_index   = '0;
    res_o.in_frame     = 1'b0;
    res_o.frame_end    = 1'b0;
    res_o.status       = sld_pkg::ST_HUNT;
    res_o.message_id   = '0;
    res_o.frame_length = '0;

    case (phase_q)
      sld_pkg::PH_SYNC: begin
        if (data_i == sld_pkg::SYNC_TWO) begin
          res_o.byte_index = sld_pkg::BYTE_INDEX_W'(1);
          res_o.in_frame   = 1'b1;
          res_o.status     = sld_pkg::ST_RECV;
          cnt_d   = CNT_W'(2);
          phase_d = sld_pkg::PH_BODY;
        end else begin
          // drop back to hunting; this byte is not rechecked as sync one
          cnt_d   = '0;
          phase_d = sld_pkg::PH_HUNT;
        end
      end
      sld_pkg::PH_BODY: begin
        res_o.byte_index = sld_pkg::BYTE_INDEX_W'(cnt_q);
        res_o.in_frame   = 1'b1;
        res_o.status     = sld_pkg::ST_RECV;
        case (cnt_q)
          CNT_W'(sld_pkg::IDX_CRC_LO): exp_d = {exp_q[15:8], data_i};
          CNT_W'(sld_pkg::IDX_CRC_HI): exp_d = {data_i, exp_q[7:0]};
          CNT_W'(sld_pkg::IDX_ID_LO):  id_d  = {id_q[15:8], data_i};
          CNT_W'(sld_pkg::IDX_ID_HI):  id_d  = {data_i, id_q[7:0]};
          CNT_W'(sld_pkg::IDX_LEN_LO): len_d = {len_q[15:8], data_i};
          CNT_W'(sld_pkg::IDX_LEN_HI): len_d = {data_i, len_q[7:0]};
          default: ;
        endcase
        if (cnt_q >= CNT_W'(sld_pkg::IDX_CRC_START)) begin
          crc_d = sld_pkg::crc_step(crc_q, data_i);
        end
        end_hit = (cnt_inc > CNT_W'(sld_pkg::IDX_LEN_HI) && 16'(cnt_inc) >= len_d) ||
                  (cnt_inc >= CNT_W'(MAX_FRAME));
        if (end_hit) begin
          res_o.frame_end    = 1'b1;
          res_o.message_id   = id_d;
          res_o.frame_length = len_d;
          if (len_d < sld_pkg::MIN_FRAME_LEN || len_d > 16'(MAX_FRAME)) begin
            res_o.status = sld_pkg::ST_LEN_ERR;
          end else if (crc_d != exp_d) begin
            res_o.status = sld_pkg::ST_CRC_ERR;
          end else begin
            res_o.status = sld_pkg::ST_GOOD;
          end
          cnt_d   = '0;
          phase_d = sld_pkg::PH_HUNT;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        if (data_i == sld_pkg::SYNC_ONE) begin
          res_o.in_frame = 1'b1;
          res_o.status   = sld_pkg::ST_RECV;
          cnt_d   = CNT_W'(1);
          crc_d   = '0;
          phase_d = sld_pkg::PH_SYNC;
        end else begin
          cnt_d   = '0;
          phase_d = sld_pkg::PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sld_pkg::PH_HUNT;
      cnt_q   <= '0;
      crc_q   <= '0;
      exp_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      exp_q   <= exp_d;
      id_q    <= id_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

[rtl/sync_length_crc16_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                     | Payload
// ---------+-----+-------------------------------+----------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: data_byte
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata, tlast = frame_end, tuser
//
// One byte per cycle sustained while m_axis does not stall: a request taken into the input
// register enters the result register when it can accept, then is offered on m_axis. Parse state,
// header capture and the CRC-16 step update as the byte enters the result register.
// Reset (rst_ni low, async) empties both registers and returns to sync hunting.
// A stall on m_axis holds the result; s_axis_tready stays high only while the input register
// is empty or its byte moves on, so at most one more byte is taken before it drops.
module sync_length_crc16_deframer #(
  parameter int MAX_FRAME = sld_pkg::MAX_FRAME_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [7:0] data_byte
  input  wire logic [sld_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [7:0] echo_byte, [17:8] byte_index, [33:18] message_id,
  // [49:34] frame_length, [55:50] zero
  output logic [sld_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast,
  // [0] in_frame, [3:1] status
  output logic [sld_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);

  localparam int RES_W = $bits(sld_pkg::res_t);

  logic                           in_valid;
  logic                           res_ready;
  logic [sld_pkg::IN_TDATA_W-1:0] in_byte;
  logic                           res_valid;
  logic [RES_W-1:0]               res_data;
  sld_pkg::res_t                  res_calc;
  sld_pkg::res_t                  res_out;

  // Input register: holds one request from s_axis.
  sld_stage #(
    .W(sld_pkg::IN_TDATA_W)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .valid_o (in_valid),
    .ready_i (res_ready),
    .data_o  (in_byte)
  );

  // Parse state advances only when the byte moves on into the result register.
  sld_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_valid && res_ready),
    .data_i (in_byte),
    .res_o  (res_calc)
  );

  // Result register: parts the parser from the downstream stall.
  sld_stage #(
    .W(RES_W)
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (res_ready),
    .data_i  (res_calc),
    .valid_o (res_valid),
    .ready_i (m_axis_tready),
    .data_o  (res_data)
  );

  assign res_out       = sld_pkg::res_t'(res_data);
  assign m_axis_tvalid = res_valid;
  assign m_axis_tlast  = res_out.frame_end;
  assign m_axis_tuser  = {res_out.status, res_out.in_frame};
  assign m_axis_tdata  = {6'b000000, res_out.frame_length, res_out.message_id,
                          res_out.byte_index, res_out.echo_byte};

endmodule

`default_nettype wire

[rtl/sld_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sync_length_crc16_deframer_defines.svh"

module sld_assert_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [sld_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                             m_axis_tlast,
  input wire logic [sld_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

  `SLD_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `SLD_ASSERT_NOW(a_end_status, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0] && (m_axis_tuser[3:1] == sld_pkg::ST_GOOD || m_axis_tuser[3:1] == sld_pkg::ST_CRC_ERR || m_axis_tuser[3:1] == sld_pkg::ST_LEN_ERR), "frame end without final status")

  `SLD_ASSERT_NOW(a_hunt_quiet, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], !m_axis_tlast && m_axis_tuser[3:1] == sld_pkg::ST_HUNT && m_axis_tdata[17:8] == '0, "hunting byte carries frame data")

  `SLD_ASSERT_NOW(a_mid_frame, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast, m_axis_tuser[3:1] == sld_pkg::ST_RECV && m_axis_tdata[49:18] == '0, "header fields shown before frame end")

endmodule

bind sync_length_crc16_deframer sld_assert_checker u_sld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[sim/sld_checker.sv]
`timescale 1ns / 1ps

// CRC helper shared by the stimulus and the checker
package sld_tb_pkg;

  localparam logic [15:0] CCITT_POLY = 16'h1021;

  // Bitwise CRC-16 CCITT, MSB first
  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                   input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CCITT_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// Watch both channels, predict one result per accepted request, compare in order
module sld_checker
  import sld_pkg::*;
  import sld_tb_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  wire logic                   m_tlast_i,
  input  wire logic [OUT_TUSER_W-1:0] m_tuser_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          results_o,
  output int                          frame_ends_o
);

  phase_e      phase;
  logic [15:0] byte_cnt;
  logic [15:0] run_crc;
  logic [15:0] crc_field;
  logic [15:0] id_field;
  logic [15:0] len_field;

  res_t expected_results[$];
  int   err_count;
  int   result_count;
  int   end_count;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at result %0d: %s got %h want %h", result_count, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Advance the deframer state by one byte and build its result
  task automatic deframe_step(input logic [7:0] b, output res_t r);
    r = '0;
    r.echo_byte = b;
    r.status    = ST_HUNT;
    case (phase)
      PH_SYNC: begin
        if (b == SYNC_TWO) begin
          r.byte_index = BYTE_INDEX_W'(1);
          r.in_frame   = 1'b1;
          r.status     = ST_RECV;
          byte_cnt     = 16'd2;
          phase        = PH_BODY;
        end else begin
          // drop back to hunting; this byte is not retried as sync one
          byte_cnt = '0;
          phase    = PH_HUNT;
        end
      end
      PH_BODY: begin
        r.byte_index = byte_cnt[BYTE_INDEX_W-1:0];
        r.in_frame   = 1'b1;
        r.status     = ST_RECV;
        case (byte_cnt)
          IDX_CRC_LO: crc_field[7:0]  = b;
          IDX_CRC_HI: crc_field[15:8] = b;
          IDX_ID_LO:  id_field[7:0]   = b;
          IDX_ID_HI:  id_field[15:8]  = b;
          IDX_LEN_LO: len_field[7:0]  = b;
          IDX_LEN_HI: len_field[15:8] = b;
          default: ;
        endcase
        if (byte_cnt >= IDX_CRC_START) run_crc = crc16_ccitt_byte(run_crc, b);
        byte_cnt = byte_cnt + 16'd1;
        if ((byte_cnt >= MIN_FRAME_LEN && byte_cnt >= len_field) || byte_cnt >= MAX_FRAME) begin
          r.frame_end = 1'b1;
          if (len_field < MIN_FRAME_LEN || len_field > MAX_FRAME) r.status = ST_LEN_ERR;
          else if (run_crc != crc_field)                         r.status = ST_CRC_ERR;
          else                                                   r.status = ST_GOOD;
          r.message_id   = id_field;
          r.frame_length = len_field;
          byte_cnt = '0;
          phase    = PH_HUNT;
        end
      end
      default: begin
        if (b == SYNC_ONE) begin
          r.in_frame = 1'b1;
          r.status   = ST_RECV;
          byte_cnt   = 16'd1;
          run_crc    = '0;
          phase      = PH_SYNC;
        end else begin
          byte_cnt = '0;
          phase    = PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got_pred;
    if (!rst_ni) begin
      phase        = PH_HUNT;
      byte_cnt     = '0;
      run_crc      = '0;
      crc_field    = '0;
      id_field     = '0;
      len_field    = '0;
      expected_results.delete();
      err_count    = 0;
      result_count = 0;
      end_count    = 0;
      errors_o     <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      frame_ends_o <= 0;
    end else begin
      // compare first so a stray result is never matched by this cycle's request
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 16'(m_tdata_i[7:0]), '0);
        end else begin
          want = expected_results.pop_front();
          check_field("echo_byte",    16'(m_tdata_i[7:0]),   16'(want.echo_byte));
          check_field("byte_index",   16'(m_tdata_i[17:8]),  16'(want.byte_index));
          check_field("message_id",   m_tdata_i[33:18],      want.message_id);
          check_field("frame_length", m_tdata_i[49:34],      want.frame_length);
          check_field("tdata pad",    16'(m_tdata_i[55:50]), '0);
          check_field("frame_end",    16'(m_tlast_i),        16'(want.frame_end));
          check_field("in_frame",     16'(m_tuser_i[0]),     16'(want.in_frame));
          check_field("status",       16'(m_tuser_i[3:1]),   16'(want.status));
        end
        if (m_tlast_i) end_count++;
        result_count++;
      end
      if (s_tvalid_i && s_tready_i) begin
        deframe_step(s_tdata_i[7:0], got_pred);
        expected_results.push_back(got_pred);
      end
      errors_o     <= err_count;
      pending_o    <= expected_results.size();
      results_o    <= result_count;
      frame_ends_o <= end_count;
    end
  end

endmodule

[sim/tb_sync_length_crc16_deframer.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the deframer; the result checking lives in sld_checker.
module tb_sync_length_crc16_deframer;
  import sld_pkg::*;
  import sld_tb_pkg::*;

  localparam int MAX_FRAME    = MAX_FRAME_DEF;
  localparam int RANDOM_ITEMS = 370;
  localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 8;    // two register stages plus margin

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  int errors;
  int pending;
  int results;
  int frame_ends;

  // shared between the sender and receiver processes, written with NBAs only
  int hold_ask = 0;
  bit quiet    = 1'b0;

  int items_sent = 0;
  bit gaps_on    = 1'b1;

  always #4 clk_i = ~clk_i;

  sync_length_crc16_deframer #(
    .MAX_FRAME(MAX_FRAME)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  sld_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_check (
    .clk_i,
    .rst_ni,
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .errors_o     (errors),
    .pending_o    (pending),
    .results_o    (results),
    .frame_ends_o (frame_ends)
  );

  // Offer one byte, maybe after an idle burst, and hold it until taken
  task automatic put_byte(input logic [7:0] b);
    int n;
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Build one frame with a correct CRC unless corrupt is set; cut > 0 truncates it
  task automatic send_frame(input logic [15:0] len, input logic [15:0] id,
                            input bit corrupt, input int cut);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    int          total;
    int          stop;
    total = (len < MIN_FRAME_LEN) ? MIN_FRAME_LEN : ((len > MAX_FRAME) ? MAX_FRAME : len);
    fb = '{SYNC_ONE, SYNC_TWO, 8'h00, 8'h00, id[7:0], id[15:8], len[7:0], len[15:8]};
    while (fb.size() < total) fb.push_back(8'($urandom_range(0, 255)));
    crc = '0;
    for (int i = IDX_CRC_START; i < total; i++) crc = crc16_ccitt_byte(crc, fb[i]);
    if (corrupt) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    fb[IDX_CRC_LO] = crc[7:0];
    fb[IDX_CRC_HI] = crc[15:8];
    stop = (cut > 0 && cut < total) ? cut : total;
    for (int i = 0; i < stop; i++) put_byte(fb[i]);
  endtask

  // Random bytes, biased toward sync one so broken syncs show up often
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) put_byte(SYNC_ONE);
      else                           put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Stop offering and wait until every predicted result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : rx_side
    int holds_done;
    int n;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_ask != holds_done) begin
        holds_done = hold_ask;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Sender: reset, directed frames, then randomized traffic
  initial begin : tx_side
    int  base;
    int  progress;
    int  pick;
    int  len;
    bit  hold_fired;
    bit  drain_fired;
    hold_fired  = 1'b0;
    drain_fired = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunting on extreme bytes
    put_byte(8'h00);
    put_byte(8'hFF);
    // sync one followed by a second sync one: the second is not a new sync
    put_byte(SYNC_ONE);
    put_byte(SYNC_ONE);
    put_byte(SYNC_TWO);
    // shortest good frame, a too-short length, a CRC mismatch
    send_frame(MIN_FRAME_LEN, 16'hFFFF, 1'b0, 0);
    send_frame(16'd7, 16'h0000, 1'b0, 0);
    send_frame(MIN_FRAME_LEN, 16'h5AA5, 1'b1, 0);

    base     = items_sent;
    progress = 0;
    while (progress < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      len     = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 96) : $urandom_range(8, 24);
      if (pick < 60)      send_frame(16'(len), 16'($urandom_range(0, 65535)), 1'b0, 0);
      else if (pick < 70) send_frame(16'(len), 16'($urandom_range(0, 65535)), 1'b1, 0);
      else if (pick < 78) send_frame(16'($urandom_range(0, 7)),
                                     16'($urandom_range(0, 65535)), 1'b0, 0);
      else if (pick < 86) send_frame(16'(len), 16'($urandom_range(0, 65535)), 1'b0,
                                     $urandom_range(1, len - 1));
      else                send_noise($urandom_range(1, 6));

      progress = items_sent - base;
      // hold the receiver off while bytes keep coming, so input backs up
      if (!hold_fired && progress >= 120) begin
        hold_fired = 1'b1;
        hold_ask  <= hold_ask + 1;
      end
      // pause the sender until the pipe is empty
      if (!drain_fired && progress >= 240) begin
        drain_fired = 1'b1;
        drain_results();
      end
      // last stretch runs at full rate on both sides
      if (progress >= RANDOM_ITEMS - 60) quiet <= 1'b1;
    end

    drain_results();
    $display("sent %0d bytes: sync hunting, broken syncs, good, corrupt, short, long frames",
             items_sent);
    $display("checked %0d results with %0d frame ends under random stalls and one long hold",
             results, frame_ends);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
